// ----- design/pps_pkg.sv -----
// shared widths, types and state codes of the priority scheduler
package pps_pkg;

    localparam int MAX_PROCS = 16;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int PNUM_W  = 5;
    localparam int OTIME_W = 21;
    localparam int OSUM_W  = 25;

    localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    // exact internal time: latest arrival plus every burst
    localparam int TIME_W = $clog2((MAX_PROCS + 1) * 65536);
    localparam int SUM_W  = $clog2(MAX_PROCS * (MAX_PROCS + 1) * 65536);
    localparam int DESC_W = ARR_W + BURST_W + PRIO_W;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_desc;

    // best candidate and earliest future arrival found by one scan
    typedef struct packed {
        logic               have;
        logic [IDX_W-1:0]   idx;
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  rem;
        logic               have_next;
        logic [ARR_W-1:0]   next_arr;
    } t_pick;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_APPLY,
        ST_ACCUM,
        ST_OUT_RD,
        ST_OUT_WR
    } t_state;

endpackage

// ----- design/pps_if.sv -----
// descriptor and result channel interfaces
interface pps_desc_if;
    import pps_pkg::*;
    logic               valid;
    logic               ready;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               last_item;
    modport source (output valid, arrival, burst, prio, last_item, input ready);
    modport sink   (input valid, arrival, burst, prio, last_item, output ready);
endinterface

interface pps_res_if;
    import pps_pkg::*;
    logic               valid;
    logic               ready;
    logic [PNUM_W-1:0]  process_number;
    logic [OTIME_W-1:0] finish_time;
    logic [OTIME_W-1:0] turnaround;
    logic [OTIME_W-1:0] waiting;
    logic [OSUM_W-1:0]  sum_turnaround;
    logic [OSUM_W-1:0]  sum_waiting;
    logic               last_result;
    modport source (output valid, process_number, finish_time, turnaround, waiting,
                    sum_turnaround, sum_waiting, last_result, input ready);
    modport sink   (input valid, process_number, finish_time, turnaround, waiting,
                    sum_turnaround, sum_waiting, last_result, output ready);
endinterface

// ----- design/pps_ram.sv -----
// generic single-write, single-read ram with registered read
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/pps_pick.sv -----
// scan comparator: tracks the best ready process and the next arrival
module pps_pick (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_chk,
    input  logic [pps_pkg::IDX_W-1:0]  i_idx,
    input  logic                       i_done,
    input  logic [pps_pkg::TIME_W-1:0] i_time,
    input  pps_pkg::t_desc             i_desc,
    input  logic [pps_pkg::TIME_W-1:0] i_rem,
    output pps_pkg::t_pick             o_pick
);
    import pps_pkg::*;

    t_pick r_pick;
    t_pick n_pick;
    logic  w_arrived;
    logic  w_better;
    logic  w_sooner;

    assign w_arrived = TIME_W'(i_desc.arrival) <= i_time;
    // higher priority wins, then earlier arrival; equal keeps the lower index
    assign w_better  = !r_pick.have || (i_desc.prio > r_pick.prio)
                     || ((i_desc.prio == r_pick.prio) && (i_desc.arrival < r_pick.arr));
    assign w_sooner  = !r_pick.have_next || (i_desc.arrival < r_pick.next_arr);

    always_comb begin
        n_pick = r_pick;
        if (i_clear) begin
            n_pick.have      = 1'b0;
            n_pick.have_next = 1'b0;
        end else if (i_chk && !i_done) begin
            if (w_arrived) begin
                if (w_better) begin
                    n_pick.have  = 1'b1;
                    n_pick.idx   = i_idx;
                    n_pick.prio  = i_desc.prio;
                    n_pick.arr   = i_desc.arrival;
                    n_pick.burst = i_desc.burst;
                    n_pick.rem   = i_rem;
                end
            end else if (w_sooner) begin
                n_pick.have_next = 1'b1;
                n_pick.next_arr  = i_desc.arrival;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick <= '0;
        end else begin
            r_pick <= n_pick;
        end
    end

    assign o_pick = r_pick;
endmodule

// ----- design/pps_out.sv -----
// result stage: derives turnaround and waiting, holds the beat until taken
module pps_out (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [pps_pkg::CNT_W-1:0]  i_idx,
    input  pps_pkg::t_desc             i_desc,
    input  logic [pps_pkg::TIME_W-1:0] i_finish,
    input  logic [pps_pkg::SUM_W-1:0]  i_sum_tat,
    input  logic [pps_pkg::SUM_W-1:0]  i_sum_wait,
    input  logic                       i_last,
    output logic                       o_free,
    pps_res_if.source                  o_res
);
    import pps_pkg::*;

    logic                r_valid;
    logic [PNUM_W-1:0]   r_num;
    logic [OTIME_W-1:0]  r_finish;
    logic [OTIME_W-1:0]  r_tat;
    logic [OTIME_W-1:0]  r_wait;
    logic [OSUM_W-1:0]   r_sum_tat;
    logic [OSUM_W-1:0]   r_sum_wait;
    logic                r_last;
    logic [CNT_W:0]      w_num;
    logic [TIME_W-1:0]   w_tat;
    logic [TIME_W-1:0]   w_wait;

    assign w_num  = {1'b0, i_idx} + (CNT_W + 1)'(1);
    assign w_tat  = i_finish - TIME_W'(i_desc.arrival);
    assign w_wait = w_tat - TIME_W'(i_desc.burst);
    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num      <= PNUM_W'(w_num);
            r_finish   <= OTIME_W'(i_finish);
            r_tat      <= OTIME_W'(w_tat);
            r_wait     <= OTIME_W'(w_wait);
            r_sum_tat  <= OSUM_W'(i_sum_tat);
            r_sum_wait <= OSUM_W'(i_sum_wait);
            r_last     <= i_last;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.process_number = r_num;
    assign o_res.finish_time    = r_finish;
    assign o_res.turnaround     = r_tat;
    assign o_res.waiting        = r_wait;
    assign o_res.sum_turnaround = r_sum_tat;
    assign o_res.sum_waiting    = r_sum_wait;
    assign o_res.last_result    = r_last;
endmodule

// ----- design/preemptive_priority_scheduler_unit.sv -----
// top level of the preemptive priority scheduler
//
//  channel    dir  modport  payload                                   beat when
//  i_desc     in   sink     arrival, burst, prio, last_item            valid && ready
//  o_result   out  source   process_number, finish/turnaround/waiting, valid && ready
//                           sum_turnaround, sum_waiting, last_result
//
// load: one descriptor beat per cycle, written into the descriptor ram
// schedule: each decision scans the table through the ram read port, then
//   decide, apply and (on completion) accumulate; at most about 3n decisions
//   for n processes
// unload: per result a ram read, then the output register load
// reset clears the control state; the rams need no clearing
// a stalled result holds the unload sequence; descriptors are taken only
//   during load, also while the last result of the previous set still waits
module preemptive_priority_scheduler_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pps_desc_if.sink   i_desc,
    pps_res_if.source  o_result
);
    import pps_pkg::*;

    t_state              r_state;
    t_state              n_state;

    logic [CNT_W-1:0]    r_cnt;        // processes held in the table
    logic [CNT_W-1:0]    r_scan;       // scan read pointer
    logic                r_chk_vld;    // ram data of r_chk_idx is valid
    logic [IDX_W-1:0]    r_chk_idx;
    logic [MAX_PROCS-1:0] r_done;
    logic [CNT_W-1:0]    r_done_cnt;
    logic [TIME_W-1:0]   r_time;
    logic [TIME_W-1:0]   r_run;
    logic [SUM_W-1:0]    r_sum_tat;
    logic [SUM_W-1:0]    r_sum_wait;
    logic [CNT_W-1:0]    r_oidx;       // unload pointer

    // control decoded from state
    logic                w_in_rdy;
    logic                w_in_acc;
    logic                w_desc_we;
    logic                w_rd_en;
    logic [IDX_W-1:0]    w_raddr;
    logic                w_dyn_we;
    logic [IDX_W-1:0]    w_dyn_waddr;
    logic [TIME_W-1:0]   w_dyn_wdata;
    logic                w_out_load;
    logic                w_scan_start;

    // datapath
    t_desc               w_wr_desc;
    logic [BURST_W-1:0]  w_burst_fix;
    t_desc               w_rd_desc;
    logic [TIME_W-1:0]   w_rd_dyn;
    t_pick               w_pick;
    logic [TIME_W-1:0]   w_gap;
    logic [TIME_W-1:0]   w_run;
    logic [TIME_W-1:0]   w_t_new;
    logic [TIME_W-1:0]   w_rem_new;
    logic                w_fin;
    logic [TIME_W-1:0]   w_tat;
    logic                w_has_room;
    logic                w_out_free;
    logic                w_out_last;

    assign i_desc.ready = w_in_rdy;
    assign w_in_acc     = i_desc.valid && w_in_rdy;
    assign w_has_room   = r_cnt < CNT_W'(MAX_PROCS);

    // a zero burst counts as one time unit
    assign w_burst_fix       = (i_desc.burst == '0) ? BURST_W'(1) : i_desc.burst;
    assign w_wr_desc.arrival = i_desc.arrival;
    assign w_wr_desc.burst   = w_burst_fix;
    assign w_wr_desc.prio    = i_desc.prio;

    // run length: to completion, or up to the next arrival if that is sooner
    assign w_gap     = TIME_W'(w_pick.next_arr) - r_time;
    assign w_run     = (w_pick.have_next && (w_gap < w_pick.rem)) ? w_gap : w_pick.rem;
    assign w_t_new   = r_time + r_run;
    assign w_rem_new = w_pick.rem - r_run;
    assign w_fin     = (w_rem_new == '0);
    assign w_tat     = r_time - TIME_W'(w_pick.arr);

    assign w_out_last   = (r_oidx + CNT_W'(1)) == r_cnt;
    assign w_scan_start = (n_state == ST_SCAN) && (r_state != ST_SCAN);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_desc.last_item) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_scan == r_cnt) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // nothing ready: jump the clock and scan again
                n_state = w_pick.have ? ST_APPLY : ST_SCAN;
            end
            ST_APPLY: begin
                n_state = w_fin ? ST_ACCUM : ST_SCAN;
            end
            ST_ACCUM: begin
                n_state = (r_done_cnt == r_cnt) ? ST_OUT_RD : ST_SCAN;
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_WR;
            end
            ST_OUT_WR: begin
                if (w_out_free) begin
                    n_state = w_out_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb begin
        w_in_rdy    = 1'b0;
        w_desc_we   = 1'b0;
        w_rd_en     = 1'b0;
        w_raddr     = r_scan[IDX_W-1:0];
        w_dyn_we    = 1'b0;
        w_dyn_waddr = r_cnt[IDX_W-1:0];
        w_dyn_wdata = TIME_W'(w_burst_fix);
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                w_in_rdy  = 1'b1;
                // descriptors past a full table are dropped
                w_desc_we = w_in_acc && w_has_room;
                w_dyn_we  = w_in_acc && w_has_room;
            end
            ST_SCAN: begin
                w_rd_en = r_scan < r_cnt;
            end
            ST_DECIDE: begin
            end
            ST_APPLY: begin
                // remaining time while running, finish time once done
                w_dyn_we    = 1'b1;
                w_dyn_waddr = w_pick.idx;
                w_dyn_wdata = w_fin ? w_t_new : w_rem_new;
            end
            ST_ACCUM: begin
            end
            ST_OUT_RD: begin
                w_rd_en = 1'b1;
                w_raddr = r_oidx[IDX_W-1:0];
            end
            ST_OUT_WR: begin
                w_out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_cnt      <= '0;
            r_scan     <= '0;
            r_chk_vld  <= 1'b0;
            r_done     <= '0;
            r_done_cnt <= '0;
            r_time     <= '0;
            r_sum_tat  <= '0;
            r_sum_wait <= '0;
            r_oidx     <= '0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= w_rd_en && (r_state == ST_SCAN);
            if (w_scan_start) begin
                r_scan <= '0;
            end else if (w_rd_en && (r_state == ST_SCAN)) begin
                r_scan <= r_scan + CNT_W'(1);
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (w_desc_we) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (w_in_acc && i_desc.last_item) begin
                        // fresh run from time zero
                        r_time     <= '0;
                        r_done     <= '0;
                        r_done_cnt <= '0;
                        r_sum_tat  <= '0;
                        r_sum_wait <= '0;
                    end
                end
                ST_SCAN: begin
                end
                ST_DECIDE: begin
                    if (!w_pick.have) begin
                        r_time <= TIME_W'(w_pick.next_arr);
                    end
                end
                ST_APPLY: begin
                    r_time <= w_t_new;
                    if (w_fin) begin
                        r_done[w_pick.idx] <= 1'b1;
                        r_done_cnt         <= r_done_cnt + CNT_W'(1);
                    end
                end
                ST_ACCUM: begin
                    r_sum_tat  <= r_sum_tat + SUM_W'(w_tat);
                    r_sum_wait <= r_sum_wait + SUM_W'(w_tat) - SUM_W'(w_pick.burst);
                    r_oidx     <= '0;
                end
                ST_OUT_RD: begin
                end
                ST_OUT_WR: begin
                    if (w_out_free) begin
                        r_oidx <= r_oidx + CNT_W'(1);
                        if (w_out_last) begin
                            r_cnt <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_scan[IDX_W-1:0];
        if (r_state == ST_DECIDE) begin
            r_run <= w_run;
        end
    end

    // static descriptor table
    pps_ram #(
        .WIDTH (DESC_W),
        .DEPTH (MAX_PROCS)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (w_desc_we),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (w_wr_desc),
        .i_re    (w_rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_desc)
    );

    // per-process remaining time, overwritten by the finish time
    pps_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_PROCS)
    ) u_dyn_ram (
        .i_clk   (i_clk),
        .i_we    (w_dyn_we),
        .i_waddr (w_dyn_waddr),
        .i_wdata (w_dyn_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_dyn)
    );

    pps_pick u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_scan_start),
        .i_chk   (r_chk_vld),
        .i_idx   (r_chk_idx),
        .i_done  (r_done[r_chk_idx]),
        .i_time  (r_time),
        .i_desc  (w_rd_desc),
        .i_rem   (w_rd_dyn),
        .o_pick  (w_pick)
    );

    pps_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_out_load),
        .i_idx      (r_oidx),
        .i_desc     (w_rd_desc),
        .i_finish   (w_rd_dyn),
        .i_sum_tat  (r_sum_tat),
        .i_sum_wait (r_sum_wait),
        .i_last     (w_out_last),
        .o_free     (w_out_free),
        .o_res      (o_result)
    );
endmodule

// ----- design/pps_chk.sv -----
// port-level assertions for the scheduler, bound to the top level
module pps_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_last,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [pps_pkg::PNUM_W-1:0]  i_out_num,
    input logic [pps_pkg::OTIME_W-1:0] i_out_finish,
    input logic [pps_pkg::OTIME_W-1:0] i_out_tat,
    input logic [pps_pkg::OTIME_W-1:0] i_out_wait,
    input logic                        i_out_last
);
    import pps_pkg::*;

    // a stalled result beat stays and holds its number, times and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid
            && $stable(i_out_num) && $stable(i_out_finish) && $stable(i_out_tat)
            && $stable(i_out_wait) && $stable(i_out_last)))
        else $error("result beat dropped or changed while stalled");

    // a new set may only load behind the final result of the previous one
    a_load_behind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_out_valid) |-> i_out_last)
        else $error("descriptor taken while results of a set are pending");

    // the closing descriptor starts scheduling, so input stops
    a_close_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("input still ready after the closing descriptor");

    // waiting never exceeds turnaround, turnaround never exceeds finish
    a_time_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_wait <= i_out_tat) && (i_out_tat <= i_out_finish)))
        else $error("result times out of order");
endmodule

bind preemptive_priority_scheduler_unit pps_chk u_pps_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_desc.valid),
    .i_in_ready   (i_desc.ready),
    .i_in_last    (i_desc.last_item),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_num    (o_result.process_number),
    .i_out_finish (o_result.finish_time),
    .i_out_tat    (o_result.turnaround),
    .i_out_wait   (o_result.waiting),
    .i_out_last   (o_result.last_result)
);

// ----- sim/tb.sv -----
// self-checking testbench for the preemptive priority scheduler: directed table, random sets
`timescale 1ns / 1ps

module tb;
    import pps_pkg::*;

    localparam int RAND_ITEMS   = 125;
    localparam int DIR_N        = 25;
    localparam int IDLE_LIMIT   = 20000;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 40;
    localparam int DRAIN_CYCLES = 100;

    // one process descriptor as held by the predictor
    typedef struct {
        int unsigned arr;
        int unsigned bst;
        int unsigned pri;
    } t_proc;

    // one result beat at the widths of the result channel
    typedef struct packed {
        logic [PNUM_W-1:0]  pnum;
        logic [OTIME_W-1:0] fin;
        logic [OTIME_W-1:0] tat;
        logic [OTIME_W-1:0] wt;
        logic [OSUM_W-1:0]  sum_tat;
        logic [OSUM_W-1:0]  sum_wt;
        logic               last;
    } t_sched_res;

    // directed row; single-process rows may carry a typed-in expectation
    typedef struct {
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] bst;
        logic [PRIO_W-1:0]  pri;
        logic               last;
        bit                 typed;
        int unsigned        fin;
        int unsigned        tat;
        int unsigned        wt;
    } t_dir_row;

    t_dir_row dir_tab [DIR_N] = '{
        // lone processes right after reset, at the extremes, and a zero burst
        '{16'd0,     16'd5,     8'd0,   1'b1, 1'b1, 5,      5,     0},
        '{16'hFFFF,  16'hFFFF,  8'hFF,  1'b1, 1'b1, 131070, 65535, 0},
        '{16'd100,   16'd0,     8'd7,   1'b1, 1'b1, 101,    1,     0},
        // nested preemption
        '{16'd0,     16'd10,    8'd1,   1'b0, 1'b0, 0, 0, 0},
        '{16'd2,     16'd3,     8'd9,   1'b0, 1'b0, 0, 0, 0},
        '{16'd4,     16'd2,     8'd5,   1'b1, 1'b0, 0, 0, 0},
        // equal priority, earlier arrival wins over lower index
        '{16'd5,     16'd4,     8'd2,   1'b0, 1'b0, 0, 0, 0},
        '{16'd3,     16'd4,     8'd2,   1'b1, 1'b0, 0, 0, 0},
        // full table: index ties, idle gaps, zero burst, last one dropped
        '{16'd40000, 16'd3,     8'd0,   1'b0, 1'b0, 0, 0, 0},
        '{16'd0,     16'd7,     8'd128, 1'b0, 1'b0, 0, 0, 0},
        '{16'd0,     16'd7,     8'd128, 1'b0, 1'b0, 0, 0, 0},
        '{16'd2,     16'hFFFF,  8'd1,   1'b0, 1'b0, 0, 0, 0},
        '{16'd3,     16'd1,     8'd255, 1'b0, 1'b0, 0, 0, 0},
        '{16'd3,     16'd1,     8'd255, 1'b0, 1'b0, 0, 0, 0},
        '{16'hFFFF,  16'd2,     8'd200, 1'b0, 1'b0, 0, 0, 0},
        '{16'd20,    16'd5,     8'd128, 1'b0, 1'b0, 0, 0, 0},
        '{16'd10,    16'd0,     8'd64,  1'b0, 1'b0, 0, 0, 0},
        '{16'h5555,  16'hAAAA,  8'h55,  1'b0, 1'b0, 0, 0, 0},
        '{16'hAAAA,  16'h5555,  8'hAA,  1'b0, 1'b0, 0, 0, 0},
        '{16'd50,    16'd4,     8'd0,   1'b0, 1'b0, 0, 0, 0},
        '{16'd50,    16'd4,     8'd0,   1'b0, 1'b0, 0, 0, 0},
        '{16'd49,    16'd9,     8'd0,   1'b0, 1'b0, 0, 0, 0},
        '{16'd1,     16'd1,     8'd254, 1'b0, 1'b0, 0, 0, 0},
        '{16'd100,   16'd30,    8'd129, 1'b0, 1'b0, 0, 0, 0},
        '{16'd7,     16'd9,     8'd255, 1'b1, 1'b0, 0, 0, 0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pps_desc_if desc_ch ();
    pps_res_if  res_ch ();

    preemptive_priority_scheduler_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_desc   (desc_ch),
        .o_result (res_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_proc       loading_procs [$];   // descriptors of the set being loaded
    t_sched_res  due_results [$];     // results still owed by the block
    int unsigned n_errors    = 0;
    int unsigned n_desc      = 0;
    int unsigned n_sets      = 0;
    int unsigned n_dropped   = 0;
    int unsigned n_results   = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;

    // preemptive priority schedule of the loaded set, results appended in load order
    function automatic void run_priority_schedule();
        int unsigned now, run, next_arr, tot_tat, tot_wt, n_done, n, tat;
        int unsigned rem [MAX_PROCS];
        int unsigned fin [MAX_PROCS];
        bit          finished [MAX_PROCS];
        bit          have, have_next;
        int          pick;
        t_sched_res  r;
        n       = loading_procs.size();
        now     = 0;
        tot_tat = 0;
        tot_wt  = 0;
        n_done  = 0;
        for (int i = 0; i < n; i++) begin
            rem[i]      = loading_procs[i].bst;
            finished[i] = 1'b0;
        end
        while (n_done < n) begin
            have      = 1'b0;
            have_next = 1'b0;
            pick      = 0;
            next_arr  = 0;
            for (int i = 0; i < n; i++) begin
                if (finished[i]) continue;
                if (loading_procs[i].arr <= now) begin
                    // higher priority, then earlier arrival; equal keeps lower index
                    if (!have || loading_procs[i].pri > loading_procs[pick].pri ||
                        (loading_procs[i].pri == loading_procs[pick].pri &&
                         loading_procs[i].arr < loading_procs[pick].arr)) begin
                        pick = i;
                        have = 1'b1;
                    end
                end else if (!have_next || loading_procs[i].arr < next_arr) begin
                    next_arr  = loading_procs[i].arr;
                    have_next = 1'b1;
                end
            end
            if (!have) begin
                now = next_arr;
                continue;
            end
            // run until done or until the next arrival may preempt
            run = rem[pick];
            if (have_next && next_arr - now < run) run = next_arr - now;
            now       += run;
            rem[pick] -= run;
            if (rem[pick] == 0) begin
                tat            = now - loading_procs[pick].arr;
                fin[pick]      = now;
                tot_tat       += tat;
                tot_wt        += tat - loading_procs[pick].bst;
                finished[pick] = 1'b1;
                n_done++;
            end
        end
        for (int i = 0; i < n; i++) begin
            tat       = fin[i] - loading_procs[i].arr;
            r.pnum    = PNUM_W'(i + 1);
            r.fin     = OTIME_W'(fin[i]);
            r.tat     = OTIME_W'(tat);
            r.wt      = OTIME_W'(tat - loading_procs[i].bst);
            r.sum_tat = OSUM_W'(tot_tat);
            r.sum_wt  = OSUM_W'(tot_wt);
            r.last    = (i == n - 1);
            due_results.push_back(r);
        end
        loading_procs.delete();
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // descriptor beats feed the predictor
    always @(posedge i_clk) begin : take_desc
        t_proc      p;
        t_sched_res typed;
        if (i_rst_n && desc_ch.valid && desc_ch.ready) begin
            if (loading_procs.size() < MAX_PROCS) begin
                p.arr = 32'(desc_ch.arrival);
                p.bst = (desc_ch.burst == '0) ? 32'd1 : 32'(desc_ch.burst);
                p.pri = 32'(desc_ch.prio);
                loading_procs.push_back(p);
            end else begin
                n_dropped++;
            end
            if (desc_ch.last_item) begin
                run_priority_schedule();
                n_sets++;
                // lone-process rows of the table are checked against typed-in values
                if (n_desc < DIR_N && dir_tab[n_desc].typed) begin
                    void'(due_results.pop_back());
                    typed.pnum    = PNUM_W'(1);
                    typed.fin     = OTIME_W'(dir_tab[n_desc].fin);
                    typed.tat     = OTIME_W'(dir_tab[n_desc].tat);
                    typed.wt      = OTIME_W'(dir_tab[n_desc].wt);
                    typed.sum_tat = OSUM_W'(dir_tab[n_desc].tat);
                    typed.sum_wt  = OSUM_W'(dir_tab[n_desc].wt);
                    typed.last    = 1'b1;
                    due_results.push_back(typed);
                end
            end
            n_desc++;
        end
    end

    // result beats against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_sched_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            if (due_results.size() == 0) begin
                $error("result beat for process %0d with nothing expected",
                       res_ch.process_number);
                n_errors++;
            end else begin
                want = due_results.pop_front();
                check_field("process_number", 32'(want.pnum),
                            32'(res_ch.process_number));
                check_field("finish_time",    32'(want.fin),     32'(res_ch.finish_time));
                check_field("turnaround",     32'(want.tat),     32'(res_ch.turnaround));
                check_field("waiting",        32'(want.wt),      32'(res_ch.waiting));
                check_field("sum_turnaround", 32'(want.sum_tat),
                            32'(res_ch.sum_turnaround));
                check_field("sum_waiting",    32'(want.sum_wt),  32'(res_ch.sum_waiting));
                check_field("last_result",    32'(want.last),    32'(res_ch.last_result));
            end
        end
    end

    // watchdog: no beat on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (desc_ch.valid && desc_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[preemptive_priority_scheduler_unit] ERROR");
            $finish;
        end
    end

    // result side: stall patterns in stretches, one long hold-off to back up the input
    initial begin : receiver
        int unsigned mode, span;
        bit          held;
        held = 1'b0;
        forever begin
            if (!held && n_results >= HOLD_AFTER) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                held = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 40);
            repeat (span) begin
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    2: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // one descriptor beat; a random gap opens each new burst
    task automatic put_desc(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] bst,
                            input logic [PRIO_W-1:0] pri, input logic last);
        if (burst_left == 0) begin
            desc_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        desc_ch.valid     <= 1'b1;
        desc_ch.arrival   <= arr;
        desc_ch.burst     <= bst;
        desc_ch.prio      <= pri;
        desc_ch.last_item <= last;
        @(posedge i_clk);
        while (!desc_ch.ready) @(posedge i_clk);
    endtask

    // stop offering and wait until the block owes nothing
    task automatic drain_results();
        desc_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // one random set: mostly short, sometimes full, now and then overfull
    task automatic send_random_set(output int unsigned n);
        int unsigned        style, pick;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] bst;
        logic [PRIO_W-1:0]  pri;
        pick = $urandom_range(0, 11);
        if (pick == 0)
            n = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 3);
        else if (pick < 4)
            n = $urandom_range(9, MAX_PROCS);
        else
            n = $urandom_range(1, 8);
        style = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            pick = (style == 3) ? $urandom_range(0, 2) : style;
            case (pick)
                0: begin
                    // dense overlap and frequent priority ties
                    arr = ARR_W'($urandom_range(0, 40));
                    bst = BURST_W'($urandom_range(1, 12));
                    pri = PRIO_W'($urandom_range(0, 3));
                end
                1: begin
                    arr = ARR_W'($urandom_range(0, 3000));
                    bst = BURST_W'($urandom_range(1, 800));
                    pri = PRIO_W'($urandom_range(0, 255));
                end
                default: begin
                    arr = ARR_W'($urandom);
                    bst = BURST_W'($urandom);
                    pri = PRIO_W'($urandom);
                end
            endcase
            if ($urandom_range(0, 19) == 0) bst = '0;
            put_desc(arr, bst, pri, k == n - 1);
        end
    endtask

    initial begin : stimulus
        int unsigned n_rand, n_set_items, set_idx;
        n_rand  = 0;
        set_idx = 0;
        desc_ch.valid     <= 1'b0;
        desc_ch.arrival   <= '0;
        desc_ch.burst     <= '0;
        desc_ch.prio      <= '0;
        desc_ch.last_item <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            put_desc(dir_tab[i].arr, dir_tab[i].bst, dir_tab[i].pri, dir_tab[i].last);

        while (n_rand < RAND_ITEMS) begin
            // once, let the block empty out completely before the next set
            if (set_idx == 5) drain_results();
            send_random_set(n_set_items);
            n_rand += n_set_items;
            set_idx++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d descriptors in %0d sets, %0d dropped on a full table",
                 n_desc, n_sets, n_dropped);
        $display("%0d result beats compared field by field, %0d mismatches",
                 n_results, n_errors);
        if (n_errors == 0)
            $display("[preemptive_priority_scheduler_unit] OK");
        else
            $display("[preemptive_priority_scheduler_unit] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/pps_pkg.sv
design/pps_if.sv
design/pps_ram.sv
design/pps_pick.sv
design/pps_out.sv
design/preemptive_priority_scheduler_unit.sv
design/pps_chk.sv
sim/tb.sv
